// File: sv/fractional_delay_thiran_allpass_macros.svh
// Assertion macros for the fractional delay block.
// Used by fractional_delay_thiran_allpass.sv; expects clk_i and rst_ni in scope.
`ifndef FRACTIONAL_DELAY_THIRAN_ALLPASS_MACROS_SVH
`define FRACTIONAL_DELAY_THIRAN_ALLPASS_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FDTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FDTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fdta_pkg.sv
// Shared constants and types for the fractional delay / Thiran allpass block.
// No dependencies.
package fdta_pkg;

  localparam int unsigned ORDER      = 4;
  localparam int unsigned MAX_DELAY  = 1024;
  localparam int unsigned LINE_DEPTH = MAX_DELAY + ORDER + 1;
  localparam int unsigned PTR_W      = $clog2(LINE_DEPTH);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned DELAY_W  = 11;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W    = PROD_W + 4;
  localparam int unsigned FRAC_SH  = 14;
  localparam int unsigned CFG_ADDR_W = 3;

  // a0 = 1.0 in Q4.14
  localparam logic signed [COEF_W-1:0] ONE_Q14 = COEF_W'(16384);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INT_DELAY  = 3'd0,
    REG_COEF_ONE   = 3'd1,
    REG_COEF_TWO   = 3'd2,
    REG_COEF_THREE = 3'd3,
    REG_COEF_FOUR  = 3'd4
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

endpackage

// File: sv/fractional_delay_thiran_allpass.sv
// Fractional delay: circular delay line plus 4th-order Thiran allpass (direct form).
// Depends on fdta_pkg and fractional_delay_thiran_allpass_macros.svh.
//
// Usage:
//   s_axis_*  : one signed Q1.15 sample per beat in.
//   m_axis_*  : one signed Q1.15 saturated sample per beat out, one per input beat.
//   cfg_*     : register writes (0 int_delay, 1..4 coefficients a1..a4, Q4.14);
//               cfg_ready_o is always high, other indices are ignored. Write only
//               while no beat is in flight.
// Path: an accepted sample is read from the delay line into the read register,
//   then filtered into the output register when the filter stage fires.
// Throughput: one sample per cycle while m_axis_tready does not stall; the
//   recursion y[n-1] -> y[n] closes inside the filter stage (parallel multipliers, adder tree, round, clamp).
// Reset: registers, pointer and filter histories clear. The delay line memory is
//   not swept; a fill mark (write pointer plus wrap flag) makes entries never
//   written read as zero, so the block takes beats right after reset.
// Stall: while m_axis_tready is low the output register holds, the filter stage
//   holds its sample, and s_axis_tready drops once both are full.
`include "fractional_delay_thiran_allpass_macros.svh"

module fractional_delay_thiran_allpass import fdta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream, tdata: [15:0] sample_in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,
  // output stream, tdata: [15:0] sample_out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COEF_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [DELAY_W-1:0] int_delay_q;
  coef_t              coef_q [1:ORDER];

  // delay line and its fill mark
  logic [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
  logic [PTR_W-1:0]    wp_q, wp_d;
  logic                wrapped_q, wrapped_d;
  logic [PTR_W-1:0]    rp;
  logic                rd_hit;

  // filter stage
  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_valid_q;
  sample_t             x_hist_q [ORDER];
  sample_t             y_hist_q [ORDER];

  // output register
  logic                out_valid_q;
  sample_t             out_q;

  logic                in_beat, fire;

  coef_t                     coef_w [0:ORDER];
  sample_t                   xn;
  logic signed [PROD_W-1:0]  px [0:ORDER];
  logic signed [PROD_W-1:0]  py [1:ORDER];
  logic signed [ACC_W-1:0]   acc, acc_rnd;
  logic signed [ACC_W-FRAC_SH-1:0] shifted;
  sample_t                   y_sat;

  logic [DELAY_W-1:0] d_clamp;
  logic [PTR_W:0]     off;

  // handshake
  assign cfg_ready_o   = 1'b1;
  assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || fire;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // read address: the sample written min(int_delay, MAX_DELAY) + ORDER - 1 beats ago
  always_comb begin
    d_clamp = (int_delay_q > DELAY_W'(MAX_DELAY)) ? DELAY_W'(MAX_DELAY) : int_delay_q;
    off     = (PTR_W+1)'(d_clamp) + (PTR_W+1)'(ORDER - 1);
    if ({1'b0, wp_q} >= off) begin
      rp = PTR_W'({1'b0, wp_q} - off);
    end else begin
      rp = PTR_W'({1'b0, wp_q} + (PTR_W+1)'(LINE_DEPTH) - off);
    end
    rd_hit = wrapped_q || (rp < wp_q);
  end

  // write pointer advance
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (in_beat) begin
      if (wp_q == PTR_W'(LINE_DEPTH - 1)) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + PTR_W'(1);
      end
    end
  end

  // delay line memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      line_mem[wp_q] <= s_axis_tdata;
      rd_data_q      <= line_mem[rp];
    end
  end

  // filter datapath
  always_comb begin
    coef_w[0] = ONE_Q14;
    for (int k = 1; k <= ORDER; k++) begin
      coef_w[k] = coef_q[k];
    end
    xn    = rd_valid_q ? sample_t'(rd_data_q) : '0;
    px[0] = coef_w[ORDER] * xn;
    for (int k = 1; k <= ORDER; k++) begin
      px[k] = coef_w[ORDER-k] * x_hist_q[k-1];
      py[k] = coef_w[k] * y_hist_q[k-1];
    end
    acc = ACC_W'(px[0]);
    for (int k = 1; k <= ORDER; k++) begin
      acc = acc + ACC_W'(px[k]) - ACC_W'(py[k]);
    end
    // round half up, then clamp to 16 bits
    acc_rnd = acc + ACC_W'(1 << (FRAC_SH - 1));
    shifted = (ACC_W-FRAC_SH)'(acc_rnd >>> FRAC_SH);
    if (shifted > (ACC_W-FRAC_SH)'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (shifted < -(ACC_W-FRAC_SH)'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = SAMPLE_W'(shifted);
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_delay_q <= '0;
      for (int k = 1; k <= ORDER; k++) coef_q[k] <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < ORDER; k++) begin
        x_hist_q[k] <= '0;
        y_hist_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_INT_DELAY:  int_delay_q <= cfg_data_i[DELAY_W-1:0];
          REG_COEF_ONE:   coef_q[1]   <= cfg_data_i;
          REG_COEF_TWO:   coef_q[2]   <= cfg_data_i;
          REG_COEF_THREE: coef_q[3]   <= cfg_data_i;
          REG_COEF_FOUR:  coef_q[4]   <= cfg_data_i;
          default: ;
        endcase
      end
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      if (in_beat) begin
        s1_valid_q <= 1'b1;
        rd_valid_q <= rd_hit;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        x_hist_q[0] <= xn;
        y_hist_q[0] <= y_sat;
        for (int k = 1; k < ORDER; k++) begin
          x_hist_q[k] <= x_hist_q[k-1];
          y_hist_q[k] <= y_hist_q[k-1];
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= y_sat;
    end
  end

  // checks
  `FDTA_ASSERT_NOW(a_wp_range, 1'b1, wp_q < PTR_W'(LINE_DEPTH), "write pointer out of range")
  `FDTA_ASSERT_NEXT(a_wrap_sticky, wrapped_q, wrapped_q, "fill mark cleared after wrap")
  `FDTA_ASSERT_NEXT(a_beat_to_stage, in_beat, s1_valid_q, "accepted beat lost before filter")
  `FDTA_ASSERT_NEXT(a_fire_to_out, fire, out_valid_q && (out_q == $past(y_sat)),
                    "filter result not registered")

endmodule
